[rtl/bdy_pkg.sv]
package bdy_pkg;

    // Field widths fixed by the interface
    localparam int REQ_W   = 23;
    localparam int ADDR_W  = 22;
    localparam int LEVEL_W = 4;
    localparam int TAG_W   = 5;
    localparam int WORD_W  = 32;
    localparam int WBIT_W  = 5;
    localparam int MBL_W   = 4;
    localparam int HDR_W   = 8;
    localparam int CIDX_W  = 1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    // Actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_MIN_BLOCK_LOG2 = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_HEADER_BYTES   = 1'd1;

    localparam logic [MBL_W-1:0] MBL_RESET = 4'd7;
    localparam logic [HDR_W-1:0] HDR_RESET = 8'd13;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  block_offset;
        logic [LEVEL_W-1:0] block_level;
    } t_res;

endpackage

[rtl/bdy_node_ram.sv]
// Free-node bitmap, one word of nodes per entry, bit-masked write
module bdy_node_ram #(
    parameter int WORDS = 64,
    parameter int WA_W  = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [WA_W-1:0]            i_waddr,
    input  logic [bdy_pkg::WORD_W-1:0] i_wmask,
    input  logic [bdy_pkg::WORD_W-1:0] i_wdata,
    input  logic [WA_W-1:0]            i_raddr,
    output logic [bdy_pkg::WORD_W-1:0] o_rdata
);

    logic [bdy_pkg::WORD_W-1:0] r_mem [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < bdy_pkg::WORD_W; b++) begin
                if (i_wmask[b]) begin
                    r_mem[i_waddr][b] <= i_wdata[b];
                end
            end
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/bdy_tag_ram.sv]
// Per-unit allocation tag store
module bdy_tag_ram #(
    parameter int UNITS = 1024,
    parameter int UA_W  = 10
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [UA_W-1:0]           i_waddr,
    input  logic [bdy_pkg::TAG_W-1:0] i_wdata,
    input  logic [UA_W-1:0]           i_raddr,
    output logic [bdy_pkg::TAG_W-1:0] o_rdata
);

    logic [bdy_pkg::TAG_W-1:0] r_mem [UNITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/buddy_allocator_core.sv]
// Binary buddy allocator over 2**POOL_LEVELS minimum blocks.
// Requests: drive i_req with start high while busy is low; the request is
// taken at that edge. action 0 allocates request_bytes (plus the header),
// action 1 frees the block starting at block_address.
// Results: exactly one per request, shown for one cycle with o_valid high.
// The receiver cannot stall; it must take o_res in that cycle.
// Configuration: i_cfg_valid/o_cfg_ready write min_block_log2 (index 0) or
// header_bytes (index 1); o_cfg_ready is low while busy or start is high.
// Sequence: an allocate steps up the levels to size the request, then for
// each level searched reads and checks each 32-node bitmap word, then
// splits down to the target level; the strobe comes in the next cycle,
// with busy low. The word scan through one read port sets the time. A free
// checks the address and the tag, then reads and checks the buddy per merge
// and once at the end; a bad free stops at one of those checks, and a
// zero-length allocate never raises busy. One request at a time; the next
// one may be taken in the strobe cycle. Reset: a clearing pass over every
// node word and tag entry empties the tag store and leaves only the root
// free; busy stays high during it. Configuration returns to 7 and 13.
module buddy_allocator_core #(
    parameter int POOL_LEVELS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bdy_pkg::t_req                       i_req,
    output logic                                o_valid,
    output bdy_pkg::t_res                       o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bdy_pkg::CIDX_W-1:0]          i_cfg_index,
    input  logic [bdy_pkg::HDR_W-1:0]           i_cfg_data
);

    localparam int P      = POOL_LEVELS;
    localparam int NODE_W = P + 1;
    localparam int WA_W   = (NODE_W > bdy_pkg::WBIT_W) ? NODE_W - bdy_pkg::WBIT_W : 1;
    localparam int WORDS  = 2 ** WA_W;
    localparam int UNITS  = 2 ** P;
    localparam int LVL_W  = $clog2(P + 1);
    localparam int C_W    = (WA_W > P) ? WA_W : P;
    localparam int SH_W   = (P + 15 > bdy_pkg::ADDR_W) ? P + 15 : bdy_pkg::ADDR_W;

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_SIZE  = 11'b00000000100,
        S_SINIT = 11'b00000001000,
        S_SRD   = 11'b00000010000,
        S_SCK   = 11'b00000100000,
        S_SPLIT = 11'b00001000000,
        S_FCHK  = 11'b00010000000,
        S_FTAG  = 11'b00100000000,
        S_MRD   = 11'b01000000000,
        S_MCK   = 11'b10000000000
    } t_state;

    t_state                       r_state, n_state;
    logic [C_W-1:0]               r_clr, n_clr;
    logic [bdy_pkg::MBL_W-1:0]    r_mbl;
    logic [bdy_pkg::HDR_W-1:0]    r_hdr;
    bdy_pkg::t_req                r_req, n_req;
    logic [bdy_pkg::REQ_W:0]      r_need, n_need;
    logic [LVL_W-1:0]             r_k, n_k;
    logic [LVL_W-1:0]             r_lt, n_lt;
    logic [WA_W-1:0]              r_w, n_w;
    logic [NODE_W-1:0]            r_node, n_node;
    logic [P-1:0]                 r_units, n_units;
    logic [LVL_W-1:0]             r_given, n_given;
    logic                         r_valid, n_valid;
    bdy_pkg::t_res                r_res, n_res;

    // memory ports
    logic                         nd_we;
    logic [WA_W-1:0]              nd_waddr, nd_raddr;
    logic [bdy_pkg::WORD_W-1:0]   nd_wmask, nd_wdata, nd_rdata;
    logic                         tg_we;
    logic [P-1:0]                 tg_waddr, tg_raddr;
    logic [bdy_pkg::TAG_W-1:0]    tg_wdata, tg_rdata;

    bdy_node_ram #(.WORDS(WORDS), .WA_W(WA_W)) u_node (
        .i_clk(i_clk), .i_we(nd_we), .i_waddr(nd_waddr), .i_wmask(nd_wmask),
        .i_wdata(nd_wdata), .i_raddr(nd_raddr), .o_rdata(nd_rdata)
    );

    bdy_tag_ram #(.UNITS(UNITS), .UA_W(P)) u_tag (
        .i_clk(i_clk), .i_we(tg_we), .i_waddr(tg_waddr), .i_wdata(tg_wdata),
        .i_raddr(tg_raddr), .o_rdata(tg_rdata)
    );

    // level geometry for the search level r_k
    logic [LVL_W-1:0]             span;
    logic [NODE_W:0]              first;
    logic [WA_W-1:0]              fw, lw;
    logic [5:0]                   fs;
    logic [bdy_pkg::WORD_W-1:0]   lmask, hits;
    logic [bdy_pkg::WBIT_W-1:0]   pe;

    always_comb begin
        span  = LVL_W'(P) - r_k;
        first = (NODE_W + 1)'(1) << span;
        fw    = WA_W'(first >> bdy_pkg::WBIT_W);
        lw    = WA_W'(((first << 1) - (NODE_W + 1)'(1)) >> bdy_pkg::WBIT_W);
        fs    = 6'(first);
        if (int'(span) < bdy_pkg::WBIT_W) begin
            lmask = bdy_pkg::WORD_W'(((33'(1) << (fs << 1)) - 33'(1))
                                     ^ ((33'(1) << fs) - 33'(1)));
        end else begin
            lmask = '1;
        end
        hits = nd_rdata & lmask;
        pe = '0;
        for (int b = bdy_pkg::WORD_W - 1; b >= 0; b--) begin
            if (hits[b]) begin
                pe = bdy_pkg::WBIT_W'(b);
            end
        end
    end

    // shared size / offset shifter
    logic [4:0]                   sh_amt;
    logic [29:0]                  lvl_size;
    logic [SH_W-1:0]              off_full;
    logic [P-1:0]                 unit_v;

    assign sh_amt   = 5'(r_mbl) + 5'(r_k);
    assign lvl_size = 30'(1) << sh_amt;
    assign off_full = SH_W'(unit_v) << r_mbl;

    // free-path decode
    logic [bdy_pkg::ADDR_W-1:0]   fmask;
    logic [bdy_pkg::ADDR_W-1:0]   funits;
    logic [bdy_pkg::TAG_W-1:0]    tlvl;
    logic [NODE_W-1:0]            buddy;

    assign fmask  = (bdy_pkg::ADDR_W'(1) << r_mbl) - bdy_pkg::ADDR_W'(1);
    assign funits = r_req.block_address >> r_mbl;
    assign tlvl   = tg_rdata - bdy_pkg::TAG_W'(1);
    assign buddy  = r_node ^ NODE_W'(1);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_req   = r_req;
        n_need  = r_need;
        n_k     = r_k;
        n_lt    = r_lt;
        n_w     = r_w;
        n_node  = r_node;
        n_units = r_units;
        n_given = r_given;
        n_valid = 1'b0;
        n_res   = r_res;
        unit_v  = r_units;
        nd_we    = 1'b0;
        nd_waddr = WA_W'(r_node >> bdy_pkg::WBIT_W);
        nd_wmask = bdy_pkg::WORD_W'(1) << bdy_pkg::WBIT_W'(r_node);
        nd_wdata = '0;
        nd_raddr = r_w;
        tg_we    = 1'b0;
        tg_waddr = r_units;
        tg_wdata = '0;
        tg_raddr = P'(funits);

        case (r_state)
            S_CLR: begin
                nd_we    = 1'b1;
                nd_waddr = WA_W'(r_clr);
                nd_wmask = '1;
                nd_wdata = (WA_W'(r_clr) == '0) ? bdy_pkg::WORD_W'(2) : '0;
                tg_we    = 1'b1;
                tg_waddr = P'(r_clr);
                n_clr    = r_clr + C_W'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req  = i_req;
                    n_need = (bdy_pkg::REQ_W + 1)'(i_req.request_bytes)
                             + (bdy_pkg::REQ_W + 1)'(r_hdr);
                    n_k    = '0;
                    if (i_req.action == bdy_pkg::ACT_FREE) begin
                        n_state = S_FCHK;
                    end else if (i_req.request_bytes == '0) begin
                        n_valid = 1'b1;
                        n_res   = '{bdy_pkg::ST_NOFIT, '0, '0};
                    end else begin
                        n_state = S_SIZE;
                    end
                end
            end
            // smallest level whose block holds the request
            S_SIZE: begin
                if (lvl_size >= 30'(r_need)) begin
                    n_lt    = r_k;
                    n_state = S_SINIT;
                end else if (r_k == LVL_W'(P)) begin
                    n_valid = 1'b1;
                    n_res   = '{bdy_pkg::ST_NOFIT, '0, '0};
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + LVL_W'(1);
                end
            end
            S_SINIT: begin
                n_w     = fw;
                n_state = S_SRD;
            end
            S_SRD: begin
                n_state = S_SCK;
            end
            // scan one bitmap word of the current level
            S_SCK: begin
                if (|hits) begin
                    n_node   = NODE_W'({r_w, pe});
                    nd_we    = 1'b1;
                    nd_waddr = r_w;
                    nd_wmask = bdy_pkg::WORD_W'(1) << pe;
                    n_state  = S_SPLIT;
                end else if (r_w != lw) begin
                    n_w     = r_w + WA_W'(1);
                    n_state = S_SRD;
                end else if (r_k != LVL_W'(P)) begin
                    n_k     = r_k + LVL_W'(1);
                    n_state = S_SINIT;
                end else begin
                    n_valid = 1'b1;
                    n_res   = '{bdy_pkg::ST_NOFIT, '0, '0};
                    n_state = S_IDLE;
                end
            end
            // split down, freeing each upper half
            S_SPLIT: begin
                if (r_k != r_lt) begin
                    nd_we    = 1'b1;
                    nd_waddr = WA_W'({r_node, 1'b1} >> bdy_pkg::WBIT_W);
                    nd_wmask = bdy_pkg::WORD_W'(1)
                               << bdy_pkg::WBIT_W'({r_node, 1'b1});
                    nd_wdata = nd_wmask;
                    n_node   = NODE_W'({r_node, 1'b0});
                    n_k      = r_k - LVL_W'(1);
                end else begin
                    unit_v   = P'((r_node & ~(NODE_W'(1) << span)) << r_lt);
                    tg_we    = 1'b1;
                    tg_waddr = unit_v;
                    tg_wdata = bdy_pkg::TAG_W'(r_lt) + bdy_pkg::TAG_W'(1);
                    n_valid  = 1'b1;
                    n_res    = '{bdy_pkg::ST_OK, off_full[bdy_pkg::ADDR_W-1:0],
                                 bdy_pkg::LEVEL_W'(r_lt)};
                    n_state  = S_IDLE;
                end
            end
            S_FCHK: begin
                n_units = P'(funits);
                if ((r_req.block_address & fmask) != '0 || (funits >> P) != '0) begin
                    n_valid = 1'b1;
                    n_res   = '{bdy_pkg::ST_BADFREE, '0, '0};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FTAG;
                end
            end
            S_FTAG: begin
                if (tg_rdata == '0 || tlvl > bdy_pkg::TAG_W'(P)) begin
                    n_valid = 1'b1;
                    n_res   = '{bdy_pkg::ST_BADFREE, '0, '0};
                    n_state = S_IDLE;
                end else begin
                    tg_we   = 1'b1;
                    n_given = LVL_W'(tlvl);
                    n_k     = LVL_W'(tlvl);
                    n_node  = (NODE_W'(1) << (LVL_W'(P) - LVL_W'(tlvl)))
                              | NODE_W'(r_units >> tlvl);
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                nd_raddr = WA_W'(buddy >> bdy_pkg::WBIT_W);
                n_state  = S_MCK;
            end
            // merge while the buddy is free
            S_MCK: begin
                nd_we = 1'b1;
                if (r_k != LVL_W'(P) && nd_rdata[bdy_pkg::WBIT_W'(buddy)]) begin
                    nd_waddr = WA_W'(buddy >> bdy_pkg::WBIT_W);
                    nd_wmask = bdy_pkg::WORD_W'(1) << bdy_pkg::WBIT_W'(buddy);
                    n_node   = r_node >> 1;
                    n_k      = r_k + LVL_W'(1);
                    n_state  = S_MRD;
                end else begin
                    nd_wdata = nd_wmask;
                    n_valid  = 1'b1;
                    n_res    = '{bdy_pkg::ST_OK, off_full[bdy_pkg::ADDR_W-1:0],
                                 bdy_pkg::LEVEL_W'(r_given)};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_mbl   <= bdy_pkg::MBL_RESET;
            r_hdr   <= bdy_pkg::HDR_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bdy_pkg::CFG_MIN_BLOCK_LOG2) begin
                    r_mbl <= i_cfg_data[bdy_pkg::MBL_W-1:0];
                end else if (i_cfg_index == bdy_pkg::CFG_HEADER_BYTES) begin
                    r_hdr <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_need  <= n_need;
        r_k     <= n_k;
        r_lt    <= n_lt;
        r_w     <= n_w;
        r_node  <= n_node;
        r_units <= n_units;
        r_given <= n_given;
        r_res   <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_res       = r_res;
    // registers change only between requests
    assign o_cfg_ready = !busy && !start;

    // checks
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted request neither busy nor answered");
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start))
        else $error("result strobe without a request");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status != bdy_pkg::ST_OK)
        |-> (o_res.block_offset == '0 && o_res.block_level == '0))
        else $error("error result carries offset or level");
    a_merge_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MCK || r_state == S_SCK) |-> (r_k <= LVL_W'(P)))
        else $error("level beyond pool");

endmodule

[verif/buddy_allocator_checker.sv]
module buddy_allocator_checker #(
    parameter int POOL_LEVELS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  bdy_pkg::t_req                i_req,
    input  logic                         o_valid,
    input  bdy_pkg::t_res                o_res,
    input  logic                         i_cfg_valid,
    input  logic                         o_cfg_ready,
    input  logic [bdy_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [bdy_pkg::HDR_W-1:0]    i_cfg_data,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_n_ok,
    output int                           o_n_nofit,
    output int                           o_n_badfree
);

    localparam int UNITS = 1 << POOL_LEVELS;
    localparam int NODES = 2 << POOL_LEVELS;
    localparam longint OFS_MASK = (64'd1 << bdy_pkg::ADDR_W) - 1;

    // Shadow allocator state
    bit                          tree_free [NODES];
    logic [bdy_pkg::TAG_W-1:0]   block_tag [UNITS];
    logic [bdy_pkg::MBL_W-1:0]   shadow_mbl;
    logic [bdy_pkg::HDR_W-1:0]   shadow_hdr;
    bdy_pkg::t_res               grants_due [$];

    function automatic bdy_pkg::t_res make_res(logic [1:0] st, longint units, int lvl);
        bdy_pkg::t_res r;
        r.status       = st;
        r.block_offset = bdy_pkg::ADDR_W'((units << shadow_mbl) & OFS_MASK);
        r.block_level  = bdy_pkg::LEVEL_W'(lvl);
        return r;
    endfunction

    function automatic bdy_pkg::t_res buddy_alloc(longint len);
        longint need;
        longint pool;
        int     lvl;
        int     hit_lvl;
        int     node;
        int     base;
        longint units;
        need = len + shadow_hdr;
        pool = 64'd1 << (shadow_mbl + POOL_LEVELS);
        node = 0;
        if (len == 0 || need > pool) return make_res(bdy_pkg::ST_NOFIT, 0, 0);
        lvl = 0;
        while (lvl < POOL_LEVELS && (64'd1 << (shadow_mbl + lvl)) < need) lvl++;
        // smallest level with a free block, lowest address first
        for (hit_lvl = lvl; hit_lvl <= POOL_LEVELS && node == 0; hit_lvl++) begin
            base = 1 << (POOL_LEVELS - hit_lvl);
            for (int n = base; n < 2 * base; n++) begin
                if (tree_free[n]) begin
                    node = n;
                    break;
                end
            end
        end
        if (node == 0) return make_res(bdy_pkg::ST_NOFIT, 0, 0);
        hit_lvl--;
        tree_free[node] = 0;
        // split down, keep lower half
        while (hit_lvl > lvl) begin
            tree_free[(node << 1) | 1] = 1;
            node = node << 1;
            hit_lvl--;
        end
        units = longint'(node - (1 << (POOL_LEVELS - lvl))) << lvl;
        block_tag[units % UNITS] = bdy_pkg::TAG_W'(lvl + 1);
        return make_res(bdy_pkg::ST_OK, units, lvl);
    endfunction

    function automatic bdy_pkg::t_res buddy_release(longint addr);
        longint units;
        int     lvl;
        int     given;
        int     node;
        if ((addr & ((64'd1 << shadow_mbl) - 1)) != 0)
            return make_res(bdy_pkg::ST_BADFREE, 0, 0);
        units = addr >> shadow_mbl;
        if (units >= UNITS) return make_res(bdy_pkg::ST_BADFREE, 0, 0);
        if (block_tag[units] == 0) return make_res(bdy_pkg::ST_BADFREE, 0, 0);
        lvl = int'(block_tag[units]) - 1;
        if (lvl > POOL_LEVELS) return make_res(bdy_pkg::ST_BADFREE, 0, 0);
        given = lvl;
        block_tag[units] = '0;
        node = (1 << (POOL_LEVELS - lvl)) + int'(units >> lvl);
        // merge while the buddy is free
        while (lvl < POOL_LEVELS && tree_free[node ^ 1]) begin
            tree_free[node ^ 1] = 0;
            node = node >> 1;
            lvl++;
        end
        tree_free[node] = 1;
        return make_res(bdy_pkg::ST_OK, units, given);
    endfunction

    always @(posedge i_clk) begin
        bdy_pkg::t_res want;
        if (!i_rst_n) begin
            foreach (tree_free[n]) tree_free[n] = 0;
            foreach (block_tag[u]) block_tag[u] = '0;
            tree_free[1] = 1;
            shadow_mbl = bdy_pkg::MBL_RESET;
            shadow_hdr = bdy_pkg::HDR_RESET;
            grants_due.delete();
            o_errors    <= 0;
            o_pending   <= 0;
            o_n_ok      <= 0;
            o_n_nofit   <= 0;
            o_n_badfree <= 0;
        end else begin
            // compare the result shown this cycle
            if (o_valid) begin
                if (grants_due.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("unexpected result: status %0d offset 0x%0h level %0d",
                                 o_res.status, o_res.block_offset, o_res.block_level);
                end else begin
                    want = grants_due.pop_front();
                    if (o_res !== want) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display({"mismatch: exp st %0d ofs 0x%0h lvl %0d, ",
                                      "got st %0d ofs 0x%0h lvl %0d"},
                                     want.status, want.block_offset, want.block_level,
                                     o_res.status, o_res.block_offset, o_res.block_level);
                    end
                    case (want.status)
                        bdy_pkg::ST_OK:    o_n_ok      <= o_n_ok + 1;
                        bdy_pkg::ST_NOFIT: o_n_nofit   <= o_n_nofit + 1;
                        default:           o_n_badfree <= o_n_badfree + 1;
                    endcase
                end
            end
            // register write
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bdy_pkg::CFG_MIN_BLOCK_LOG2)
                    shadow_mbl = i_cfg_data[bdy_pkg::MBL_W-1:0];
                else shadow_hdr = i_cfg_data;
            end
            // accepted request
            if (start && !busy) begin
                if (i_req.action == bdy_pkg::ACT_ALLOC)
                    grants_due.push_back(buddy_alloc(i_req.request_bytes));
                else grants_due.push_back(buddy_release(i_req.block_address));
            end
            o_pending <= grants_due.size();
        end
    end

endmodule

[verif/buddy_allocator_core_test.sv]
module buddy_allocator_core_test;

    localparam int  POOL_LEVELS = 10;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  RANDOM_REQS = 1130;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    bdy_pkg::t_req                i_req;
    logic                         o_valid;
    bdy_pkg::t_res                o_res;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [bdy_pkg::CIDX_W-1:0]   i_cfg_index;
    logic [bdy_pkg::HDR_W-1:0]    i_cfg_data;

    int errors, pending, n_ok, n_nofit, n_badfree;
    int cycles;

    // stimulus-side view of live blocks, in minimum units
    int                          live_units [$];
    logic [bdy_pkg::MBL_W-1:0]   cur_mbl;
    logic                        last_action;

    buddy_allocator_core #(.POOL_LEVELS(POOL_LEVELS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_valid(o_valid), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    buddy_allocator_checker #(.POOL_LEVELS(POOL_LEVELS)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_valid(o_valid), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_n_ok(n_ok), .o_n_nofit(n_nofit),
        .o_n_badfree(n_badfree)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // track grants so frees can target real blocks
    always @(posedge i_clk) begin
        if (start && !busy) last_action <= i_req.action;
        if (o_valid && o_res.status == bdy_pkg::ST_OK && last_action == bdy_pkg::ACT_ALLOC)
            live_units.push_back(int'(o_res.block_offset >> cur_mbl));
    end

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic issue(logic act, logic [bdy_pkg::REQ_W-1:0] len,
                         logic [bdy_pkg::ADDR_W-1:0] addr);
        start <= 1'b1;
        i_req <= '{action: act, request_bytes: len, block_address: addr};
        do @(posedge i_clk); while (busy);
        idle_gap();
    endtask

    task automatic write_reg(logic [bdy_pkg::CIDX_W-1:0] idx,
                             logic [bdy_pkg::HDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == bdy_pkg::CFG_MIN_BLOCK_LOG2) cur_mbl = data[bdy_pkg::MBL_W-1:0];
    endtask

    // drain: every request yields a result, then a margin for the block
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic random_request();
        int pick;
        int sz;
        int k;
        int u;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            sz = $urandom_range(0, 5);
            issue(bdy_pkg::ACT_ALLOC,
                  bdy_pkg::REQ_W'($urandom_range(1, 1 << (cur_mbl + sz))), '0);
        end else if (pick < 90 && live_units.size() > 0) begin
            k = $urandom_range(0, live_units.size() - 1);
            u = live_units[k];
            live_units.delete(k);
            issue(bdy_pkg::ACT_FREE, '0, bdy_pkg::ADDR_W'(longint'(u) << cur_mbl));
        end else begin
            issue(1'($urandom_range(0, 1)), bdy_pkg::REQ_W'($urandom()),
                  bdy_pkg::ADDR_W'($urandom()));
        end
    endtask

    initial begin
        logic [bdy_pkg::MBL_W-1:0] mbl_set [5];
        logic [bdy_pkg::HDR_W-1:0] hdr_set [5];
        int per_phase;
        mbl_set = '{4'd4, 4'd12, 4'd0, 4'd15, 4'd9};
        hdr_set = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd40};
        cycles = 0;
        cur_mbl = bdy_pkg::MBL_RESET;
        last_action = bdy_pkg::ACT_ALLOC;
        start = 0;
        i_req = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // directed requests at reset settings
        issue(bdy_pkg::ACT_ALLOC, '0, '0);                      // zero length
        issue(bdy_pkg::ACT_ALLOC, 23'd4194304, '0);             // far too large
        issue(bdy_pkg::ACT_ALLOC, 23'h7FFFFF, '0);
        issue(bdy_pkg::ACT_ALLOC, 23'd131059, '0);              // fills whole pool
        issue(bdy_pkg::ACT_ALLOC, 23'd1, '0);                   // pool exhausted
        issue(bdy_pkg::ACT_FREE, '0, 22'd0);                    // root block
        issue(bdy_pkg::ACT_FREE, '0, 22'd0);                    // double free
        issue(bdy_pkg::ACT_ALLOC, 23'd131060, '0);              // one byte over
        issue(bdy_pkg::ACT_ALLOC, 23'd1, '0);
        issue(bdy_pkg::ACT_ALLOC, 23'd115, '0);                 // exactly one unit
        issue(bdy_pkg::ACT_ALLOC, 23'd116, '0);                 // spills to level 1
        issue(bdy_pkg::ACT_FREE, '0, 22'd64);                   // misaligned
        issue(bdy_pkg::ACT_FREE, '0, 22'h3FFFFF);               // outside, misaligned
        issue(bdy_pkg::ACT_FREE, '0, 22'h3FFF80);               // outside pool
        issue(bdy_pkg::ACT_FREE, '0, 22'd384);                  // aligned, not a start
        issue(bdy_pkg::ACT_FREE, '0, 22'd128);
        issue(bdy_pkg::ACT_FREE, '0, 22'd0);
        issue(bdy_pkg::ACT_FREE, '0, 22'd256);                  // merges back to root
        settle();
        live_units.delete();

        per_phase = RANDOM_REQS / 6;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                settle();
                write_reg(bdy_pkg::CFG_MIN_BLOCK_LOG2, {4'($urandom()), mbl_set[ph-1]});
                write_reg(bdy_pkg::CFG_HEADER_BYTES, hdr_set[ph-1]);
            end
            repeat (per_phase) random_request();
        end
        settle();
        repeat (100) @(posedge i_clk);

        $display("requests checked: %0d granted/freed, %0d no-fit, %0d bad free",
                 n_ok, n_nofit, n_badfree);
        $display("six register settings, block size exponent 0 to 15, header 0 to 255");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/bdy_pkg.sv
rtl/bdy_node_ram.sv
rtl/bdy_tag_ram.sv
rtl/buddy_allocator_core.sv
verif/buddy_allocator_checker.sv
verif/buddy_allocator_core_test.sv
